[src/pie_pkg.sv]
// shared constants and types for the peak interval estimator
package pie_pkg;

   localparam int unsigned SAMPLE_W    = 24;
   localparam int unsigned MAX_SAMPLES = 65536;
   localparam int unsigned SEEN_W      = 17;
   localparam int unsigned IDX_W       = 16;
   localparam int unsigned CNT_W       = 17;
   localparam int unsigned FRAC_W      = 8;
   localparam int unsigned QUO_W       = IDX_W + FRAC_W;
   localparam int unsigned MEAN_W      = 25;
   localparam int unsigned WIN_SPAN    = 5;
   localparam int unsigned WIN_DEPTH   = WIN_SPAN - 1;
   localparam int unsigned KOFF_W      = 3;
   localparam int unsigned DIV_STEP_W  = $clog2(QUO_W);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_SAMPLES);
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   typedef logic [WIN_SPAN-1:0][SAMPLE_W-1:0] window_type;

   // one finished sequence handed from the front to the divider
   typedef struct packed {
      logic [IDX_W-1:0]  span;
      logic [CNT_W-1:0]  peaks;
      logic [SEEN_W-1:0] seen;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

endpackage

[src/pie_ifs.sv]
// request and response channel interfaces
interface pie_req_if import pie_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                is_last;

   modport source (output valid, output sample, output is_last, input ready);
   modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface pie_rsp_if import pie_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MEAN_W-1:0] mean_interval;
   logic [CNT_W-1:0]  peak_total;
   logic              too_few_peaks;

   modport source (output valid, output mean_interval, output peak_total,
                   output too_few_peaks, input ready);
   modport sink   (input valid, input mean_interval, input peak_total,
                   input too_few_peaks, output ready);
endinterface

[src/pie_front.sv]
// sample window, peak detection and per-sequence bookkeeping
module pie_front import pie_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   pie_req_if.sink req_bus,
   output logic    push_valid,
   output job_type push_job,
   input  logic    push_ready
);

   logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] win_ff, win_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              txn;
   logic              take;
   logic              seq_end;
   logic              have_any;
   window_type        w;
   logic [IDX_W-1:0]  n_eff;
   logic [WIN_SPAN-1:0] pos_ok;
   logic              peak2, peak1, peak0, hit;
   logic [KOFF_W-1:0] koff;
   logic [IDX_W-1:0]  peak_idx;
   logic [IDX_W-1:0]  first_new, last_new;
   logic [CNT_W-1:0]  count_new;
   logic [SEEN_W-1:0] seen_new;

   // candidate at window offset kc beats every present neighbor within two
   function automatic logic peak_at(window_type win, logic [WIN_SPAN-1:0] ok,
                                    logic [KOFF_W-1:0] kc);
      logic found;
      found = ok[kc];
      for (int k = 0; k < WIN_SPAN; k++) begin
         if ((k != int'(kc)) && (k + 2 >= int'(kc)) && (k <= int'(kc) + 2) &&
             ok[k] && !(win[kc] > win[k])) begin
            found = 1'b0;
         end
      end
      return found;
   endfunction

   assign req_bus.ready = push_ready;
   assign txn     = req_bus.valid && req_bus.ready;
   assign take    = txn && (seen_ff < SEEN_MAX);
   assign seq_end = txn && req_bus.is_last;

   always_comb begin
      // newest first; a dropped sample leaves the stored window in place
      if (take) begin
         w[0] = req_bus.sample;
         for (int k = 0; k < WIN_DEPTH; k++) begin
            w[k+1] = win_ff[k];
         end
         n_eff = seen_ff[IDX_W-1:0];
      end else begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            w[k] = win_ff[k];
         end
         w[WIN_DEPTH] = '0;
         n_eff = IDX_W'(seen_ff - SEEN_W'(1));
      end
      have_any = take || (seen_ff != '0);
      for (int k = 0; k < WIN_SPAN; k++) begin
         pos_ok[k] = have_any && (n_eff >= IDX_W'(k));
      end

      // peaks sit at least three apart, so at most one of these fires
      peak2 = take    && peak_at(w, pos_ok, KOFF_W'(2));
      peak1 = seq_end && peak_at(w, pos_ok, KOFF_W'(1));
      peak0 = seq_end && peak_at(w, pos_ok, KOFF_W'(0));
      hit   = peak2 || peak1 || peak0;
      priority if (peak2) begin
         koff = KOFF_W'(2);
      end else if (peak1) begin
         koff = KOFF_W'(1);
      end else begin
         koff = KOFF_W'(0);
      end
      peak_idx = n_eff - IDX_W'(koff);

      first_new = first_ff;
      last_new  = last_ff;
      count_new = count_ff;
      if (hit) begin
         if (count_ff == '0) begin
            first_new = peak_idx;
         end
         last_new = peak_idx;
         if (count_ff != CNT_MAX) begin
            count_new = count_ff + CNT_W'(1);
         end
      end
      seen_new = take ? seen_ff + SEEN_W'(1) : seen_ff;

      push_valid     = seq_end;
      push_job.span  = last_new - first_new;
      push_job.peaks = count_new;
      push_job.seen  = seen_new;

      win_in = win_ff;
      if (take) begin
         win_in[0] = req_bus.sample;
         for (int k = 1; k < WIN_DEPTH; k++) begin
            win_in[k] = win_ff[k-1];
         end
      end

      if (seq_end) begin
         seen_in  = '0;
         first_in = '0;
         last_in  = '0;
         count_in = '0;
      end else begin
         seen_in  = seen_new;
         first_in = first_new;
         last_in  = last_new;
         count_in = count_new;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         seen_ff  <= '0;
         first_ff <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/pie_job_queue.sv]
// two-entry queue of finished sequences between front and divider
module pie_job_queue import pie_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_ready,
   output logic    pop_valid,
   output job_type pop_job,
   input  logic    pop_ready
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign push_ready = (fill_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QUEUE_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[src/pie_back.sv]
// radix-2 divider for the mean spacing and the response register
module pie_back import pie_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  job_type   pop_job,
   output logic      pop_ready,
   pie_rsp_if.source rsp_bus
);

   back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        div_ff, div_in;
   logic [DIV_STEP_W-1:0]   step_ff, step_in;
   logic [MEAN_W-1:0]       mean_ff, mean_in;
   logic [CNT_W-1:0]        peaks_ff, peaks_in;
   logic                    few_ff, few_in;
   logic [CNT_W:0]          trial;

   assign rsp_bus.valid         = (state_ff == BACK_DONE);
   assign rsp_bus.mean_interval = mean_ff;
   assign rsp_bus.peak_total    = peaks_ff;
   assign rsp_bus.too_few_peaks = few_ff;

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      step_in   = step_ff;
      mean_in   = mean_ff;
      peaks_in  = peaks_ff;
      few_in    = few_ff;
      pop_ready = 1'b0;
      trial     = {rem_ff, quo_ff[QUO_W-1]} - {1'b0, div_ff};

      unique case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               peaks_in = pop_job.peaks;
               if (pop_job.peaks <= CNT_W'(1)) begin
                  // no spacing to average: report the sample count
                  mean_in  = {pop_job.seen, FRAC_W'(0)};
                  few_in   = 1'b1;
                  state_in = BACK_DONE;
               end else begin
                  rem_in   = '0;
                  quo_in   = {pop_job.span, FRAC_W'(0)};
                  div_in   = pop_job.peaks - CNT_W'(1);
                  step_in  = '0;
                  few_in   = 1'b0;
                  state_in = BACK_DIV;
               end
            end
         end
         BACK_DIV: begin
            if (!trial[CNT_W]) begin
               rem_in = trial[CNT_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[CNT_W-2:0], quo_ff[QUO_W-1]};
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            step_in = step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(QUO_W - 1)) begin
               mean_in  = MEAN_W'(quo_in);
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (rsp_bus.ready) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      step_ff  <= step_in;
      mean_ff  <= mean_in;
      peaks_ff <= peaks_in;
      few_ff   <= few_in;
   end

endmodule

[src/peak_interval_estimator.sv]
// top level of the peak interval estimator
// throughput: one sample transaction per cycle while the job queue has room
// a sequence with at most one peak is answered straight from the queue; otherwise the
//   response waits for the 24-step radix-2 divider in the back end
// a queue of two finished sequences lets short sequences stream behind a busy divider
// reset: synchronous, active high; clears counts, queue and divider state, no clearing pass
module peak_interval_estimator import pie_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pie_req_if.sink   req_bus,
   pie_rsp_if.source rsp_bus
);

   // front to queue
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // queue to divider
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // front end: sliding window of the four previous samples, peak test two
   // samples behind the input, trailing positions resolved on the last sample
   pie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // finished sequences wait here while the divider works
   pie_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // back end: span scaled to Q.8 divided by peak count minus one, one
   // quotient bit per cycle, result held until the response is taken
   pie_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

[src/pie_checker.sv]
// port-level checks on the estimator response channel and its bind
module pie_checker import pie_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MEAN_W-1:0] mean_interval,
   input logic [CNT_W-1:0]  peak_total,
   input logic              too_few_peaks
);

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mean_interval) &&
         $stable(peak_total) && $stable(too_few_peaks))
      else $error("response changed while stalled");

   // the fallback flag agrees with the peak count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (too_few_peaks == (peak_total <= CNT_W'(1))))
      else $error("too_few_peaks disagrees with peak_total");

   // fallback interval is a whole sample count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && too_few_peaks |-> (mean_interval[FRAC_W-1:0] == '0))
      else $error("sample count fallback has fraction bits");

   // no response right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind peak_interval_estimator pie_checker u_pie_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .mean_interval (rsp_bus.mean_interval),
   .peak_total    (rsp_bus.peak_total),
   .too_few_peaks (rsp_bus.too_few_peaks)
);

[sim/tb.sv]
// self-checking testbench for the peak interval estimator
`timescale 1ns / 100ps

module tb import pie_pkg::*; ();

   // a run with no transaction on either channel for this long is hung
   localparam int STALL_LIMIT = 3000;
   // cycles allowed after the last response, more than the divider needs for one sequence
   localparam int TAIL_CYCLES = 40;

   // one expected response
   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic [CNT_W-1:0]  total;
      logic              few;
   } interval_type;

   // content patterns for random sequences
   typedef enum int {
      SHAPE_TIES,
      SHAPE_FULL,
      SHAPE_SPIKES,
      SHAPE_EXTREMES
   } shape_type;

   logic clock;
   logic reset;

   pie_req_if req_bus ();
   pie_rsp_if rsp_bus ();

   peak_interval_estimator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ---------------------------------------------------------------
   // predictor state: a copy of the sequence tracking in the block
   // ---------------------------------------------------------------
   logic [SAMPLE_W-1:0] recent_hist [WIN_DEPTH];   // newest first
   int unsigned         seen_count;
   int unsigned         first_peak;
   int unsigned         last_peak;
   int unsigned         peak_tally;
   interval_type        expected_intervals [$];

   // run control and bookkeeping
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_left;
   int stall_cycles;
   int mismatches;
   int samples_sent;
   int sequences_checked;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // back to the state after reset, also after every finished sequence
   function automatic void clear_estimate();
      for (int i = 0; i < WIN_DEPTH; i++) recent_hist[i] = '0;
      seen_count = 0;
      first_peak = 0;
      last_peak  = 0;
      peak_tally = 0;
   endfunction

   // win[k] is the sample at index newest-k; cand is the position under test
   function automatic void try_peak(input logic [SAMPLE_W-1:0] win [WIN_SPAN],
                                    input int newest, input int cand);
      int  idx;
      int  d;
      logic hit;
      if (cand < 0 || cand > newest || newest - cand > WIN_DEPTH) return;
      hit = 1'b1;
      for (d = -2; d <= 2; d++) begin
         idx = cand + d;
         // neighbors past either end are absent and never block a peak
         if (d != 0 && idx >= 0 && idx <= newest && newest - idx <= WIN_DEPTH) begin
            if (win[newest - cand] <= win[newest - idx]) hit = 1'b0;
         end
      end
      if (hit) begin
         if (peak_tally == 0) first_peak = cand;
         last_peak = cand;
         if (peak_tally < CNT_MAX) peak_tally++;
      end
   endfunction

   // advance the estimate by one accepted sample, queue a response on the last one
   function automatic void track_sample(input logic [SAMPLE_W-1:0] s, input logic l);
      logic [SAMPLE_W-1:0] win [WIN_SPAN];
      int                  newest;
      int                  i;
      int                  c;
      longint unsigned     span;
      interval_type        res;
      if (seen_count < MAX_SAMPLES) begin
         win[0] = s;
         for (i = 0; i < WIN_DEPTH; i++) win[i + 1] = recent_hist[i];
         seen_count++;
         newest = int'(seen_count) - 1;
         // detection trails the input by two samples
         try_peak(win, newest, newest - 2);
         for (i = 0; i < WIN_DEPTH; i++) recent_hist[i] = win[i];
      end else begin
         // saturated: the sample is dropped, the window stays as it was
         for (i = 0; i < WIN_DEPTH; i++) win[i] = recent_hist[i];
         win[WIN_DEPTH] = '0;
         newest = int'(seen_count) - 1;
      end
      if (!l) return;
      // resolve the trailing positions, or every position of a short sequence
      if (newest >= 0) begin
         for (c = (newest >= 2) ? newest - 1 : 0; c <= newest; c++) try_peak(win, newest, c);
      end
      if (peak_tally <= 1) begin
         res.mean = MEAN_W'(seen_count << FRAC_W);
         res.few  = 1'b1;
      end else begin
         span     = longint'(last_peak - first_peak);
         res.mean = MEAN_W'((span << FRAC_W) / longint'(peak_tally - 1));
         res.few  = 1'b0;
      end
      res.total = CNT_W'(peak_tally);
      expected_intervals.push_back(res);
      clear_estimate();
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // offer one sample, predict once the transaction has gone through
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic l);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.sample  <= s;
      req_bus.is_last <= l;
      do @(posedge clock); while (!req_bus.ready);
      track_sample(s, l);
      samples_sent++;
   endtask

   // sender goes quiet until every queued response has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_intervals.size() != 0) @(posedge clock);
   endtask

   task automatic send_list(input logic [SAMPLE_W-1:0] seq [$]);
      for (int i = 0; i < seq.size(); i++) send_sample(seq[i], i == seq.size() - 1);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input shape_type shape);
      unique case (shape)
         SHAPE_TIES:   return SAMPLE_W'($urandom_range(3));
         SHAPE_FULL:   return SAMPLE_W'($urandom);
         SHAPE_SPIKES: begin
            if ($urandom_range(4) == 0) return SAMPLE_W'($urandom);
            return SAMPLE_W'($urandom_range(255));
         end
         default:      return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   // mostly short sequences, a few long ones
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(1, 12);
      if (roll < 95) return $urandom_range(13, 60);
      return $urandom_range(61, 200);
   endfunction

   task automatic send_sequence(input int len, input shape_type shape);
      for (int i = 0; i < len; i++) send_sample(pick_sample(shape), i == len - 1);
   endtask

   // ---------------------------------------------------------------
   // response side: random ready, plus a long hold on request
   // ---------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // compare every response transaction with the oldest prediction
   always @(posedge clock) begin
      interval_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_intervals.size() == 0) begin
            report_mismatch("response with no sequence pending");
         end else begin
            want = expected_intervals.pop_front();
            sequences_checked++;
            if (rsp_bus.mean_interval !== want.mean)
               report_mismatch($sformatf("mean_interval %h, expected %h",
                                         rsp_bus.mean_interval, want.mean));
            if (rsp_bus.peak_total !== want.total)
               report_mismatch($sformatf("peak_total %0d, expected %0d",
                                         rsp_bus.peak_total, want.total));
            if (rsp_bus.too_few_peaks !== want.few)
               report_mismatch($sformatf("too_few_peaks %b, expected %b",
                                         rsp_bus.too_few_peaks, want.few));
         end
      end
   end

   // watchdog: ends a run that stops moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("no transaction for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, expected_intervals.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // hand-picked sequences: single and double samples, ties, extremes, uneven spacing
   task automatic test_directed_shapes();
      logic [SAMPLE_W-1:0] seq [$];
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      // single sample, always a peak since both sides are absent
      seq = {24'h000000};
      send_list(seq);
      seq = {24'hFFFFFF};
      send_list(seq);
      // two samples, the larger one wins
      seq = {24'h000003, 24'h000007};
      send_list(seq);
      // equal pair: no peak at all
      seq = {24'h000004, 24'h000004};
      send_list(seq);
      // outer maxima tie across the two-sample reach
      seq = {24'hFFFFFF, 24'h000000, 24'hFFFFFF};
      send_list(seq);
      // two peaks three apart, trailing samples rising
      seq = {24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h000002};
      send_list(seq);
      // three peaks, spacing with a fraction, last peak on the final sample
      seq = {24'h000009, 24'h000000, 24'h000000, 24'h000008, 24'h000000,
             24'h000000, 24'h000001, 24'h800000};
      send_list(seq);
      wait_drained();
   endtask

   task automatic test_random_stream(input int req_pct, input int rsp_pct, input int budget);
      int stop_at;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      stop_at = samples_sent + budget;
      while (samples_sent < stop_at) send_sequence(pick_length(), shape_type'($urandom_range(3)));
      wait_drained();
   endtask

   // receiver stalls for a long stretch while short sequences keep coming
   task automatic test_output_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left = 200;
      repeat (30) send_sequence($urandom_range(3, 6), SHAPE_SPIKES);
      req_bus.valid <= 1'b0;
      while (hold_left > 0) @(posedge clock);
      wait_drained();
   endtask

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.sample  <= '0;
      req_bus.is_last <= 1'b0;
      reset           <= 1'b1;
      req_idle_pct      = 0;
      rsp_idle_pct      = 0;
      hold_left         = 0;
      mismatches        = 0;
      samples_sent      = 0;
      sequences_checked = 0;
      clear_estimate();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_shapes();
      // sender gaps light, receiver mostly stalled; then the reverse; then no gaps
      test_random_stream(18, 76, 220);
      test_random_stream(76, 18, 220);
      test_random_stream(0, 0, 220);
      test_output_backpressure();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d samples in %0d sequences: short and long, ties, extremes,",
               samples_sent, sequences_checked);
      $display("uneven gaps on both sides and a long output stall that fills the queue");
      if (mismatches == 0 && expected_intervals.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  expected_intervals.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
